FILE: hw/rtl/ptds_pkg.sv
package ptds_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_FINISH
  } state_e;

endpackage

FILE: hw/rtl/prime_trial_division_scan_unit.sv
// Channel  | Handshake                | Fields
// input    | in_valid_i / in_stall_o  | value_i, last_item_i
// output   | out_valid_o / out_stall_i| prime_flag_o, any_prime_o, last_result_o
//
// One beat at a time; in_stall_o is high from acceptance until the result
// moves into the output register. Negative values, 0, 1 and 2 go straight
// to ST_FINISH. Otherwise each trial divisor takes one bound check in ST_CHECK
// plus one remainder bit per cycle in ST_DIV, with divisors tried from 2 up
// to sqrt(value) in the worst case. A stalled output holds the finished result and
// delays the handoff only. rst_ni clears the FSM, valid and the array flag.
module prime_trial_division_scan_unit #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic signed [VALUE_WIDTH-1:0] value_i,
  input  logic                          last_item_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          prime_flag_o,
  output logic                          any_prime_o,
  output logic                          last_result_o
);

  localparam int W  = VALUE_WIDTH;
  localparam int CW = $clog2(VALUE_WIDTH);

  ptds_pkg::state_e state_q, state_d;

  logic [W-1:0]  v_q, v_d;
  logic [W-1:0]  vsh_q, vsh_d;
  logic [W-1:0]  div_q, div_d;
  logic [W:0]    sq_q, sq_d;
  logic [W-1:0]  rem_q, rem_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          prime_q, prime_d;
  logic          last_q, last_d;

  logic out_valid_q, out_valid_d;
  logic prime_flag_q, prime_flag_d;
  logic any_prime_q, any_prime_d;
  logic last_res_q, last_res_d;
  logic seen_q, seen_d;

  logic [W:0] rem_sh;
  logic [W:0] rem_sub;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && !in_stall_o;
  assign out_acc = out_valid_q && !out_stall_i;
  assign rem_sh  = {rem_q, vsh_q[W-1]};
  assign rem_sub = rem_sh - {1'b0, div_q};

  always_comb begin
    state_d      = state_q;
    v_d          = v_q;
    vsh_d        = vsh_q;
    div_d        = div_q;
    sq_d         = sq_q;
    rem_d        = rem_q;
    cnt_d        = cnt_q;
    prime_d      = prime_q;
    last_d       = last_q;
    out_valid_d  = out_valid_q && !out_acc;
    prime_flag_d = prime_flag_q;
    any_prime_d  = any_prime_q;
    last_res_d   = last_res_q;
    seen_d       = seen_q;
    in_stall_o   = (state_q != ptds_pkg::ST_IDLE);
    unique case (state_q)
      ptds_pkg::ST_IDLE: begin
        if (in_acc) begin
          v_d    = value_i;
          last_d = last_item_i;
          div_d  = W'(2);
          sq_d   = (W+1)'(4);
          priority if (value_i[W-1]) begin
            prime_d = 1'b0;
            state_d = ptds_pkg::ST_FINISH;
          end else if (value_i <= W'(1)) begin
            prime_d = 1'b0;
            state_d = ptds_pkg::ST_FINISH;
          end else if (value_i == W'(2)) begin
            prime_d = 1'b1;
            state_d = ptds_pkg::ST_FINISH;
          end else begin
            state_d = ptds_pkg::ST_CHECK;
          end
        end
      end
      ptds_pkg::ST_CHECK: begin
        if (sq_q > {1'b0, v_q}) begin
          prime_d = 1'b1;
          state_d = ptds_pkg::ST_FINISH;
        end else begin
          vsh_d   = v_q;
          rem_d   = '0;
          cnt_d   = CW'(W - 1);
          state_d = ptds_pkg::ST_DIV;
        end
      end
      ptds_pkg::ST_DIV: begin
        vsh_d = {vsh_q[W-2:0], 1'b0};
        rem_d = rem_sub[W] ? rem_sh[W-1:0] : rem_sub[W-1:0];
        cnt_d = cnt_q - CW'(1);
        if (cnt_q == '0) begin
          if (rem_d == '0) begin
            prime_d = 1'b0;
            state_d = ptds_pkg::ST_FINISH;
          end else begin
            sq_d    = sq_q + {div_q, 1'b0} + (W+1)'(1);
            div_d   = div_q + W'(1);
            state_d = ptds_pkg::ST_CHECK;
          end
        end
      end
      ptds_pkg::ST_FINISH: begin
        if (!out_valid_q || out_acc) begin
          out_valid_d  = 1'b1;
          prime_flag_d = prime_q;
          any_prime_d  = seen_q || prime_q;
          last_res_d   = last_q;
          seen_d       = last_q ? 1'b0 : (seen_q || prime_q);
          state_d      = ptds_pkg::ST_IDLE;
        end
      end
      default: state_d = ptds_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ptds_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      seen_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      seen_q      <= seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    v_q          <= v_d;
    vsh_q        <= vsh_d;
    div_q        <= div_d;
    sq_q         <= sq_d;
    rem_q        <= rem_d;
    cnt_q        <= cnt_d;
    prime_q      <= prime_d;
    last_q       <= last_d;
    prime_flag_q <= prime_flag_d;
    any_prime_q  <= any_prime_d;
    last_res_q   <= last_res_d;
  end

  assign out_valid_o   = out_valid_q;
  assign prime_flag_o  = prime_flag_q;
  assign any_prime_o   = any_prime_q;
  assign last_result_o = last_res_q;

endmodule

FILE: hw/rtl/ptds_checker.sv
module ptds_checker #(
  parameter int VALUE_WIDTH = 32
) (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_stall_o,
  input logic signed [VALUE_WIDTH-1:0] value_i,
  input logic                          last_item_i,
  input logic                          out_valid_o,
  input logic                          out_stall_i,
  input logic                          prime_flag_o,
  input logic                          any_prime_o,
  input logic                          last_result_o
);

  logic unused_in;
  assign unused_in = ^{value_i, last_item_i};

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output beat dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(prime_flag_o) && $stable(any_prime_o) && $stable(last_result_o))
    else $error("stalled output beat changed");

  a_any_covers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && prime_flag_o |-> any_prime_o)
    else $error("prime result without array flag");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second beat accepted while busy");

endmodule

bind prime_trial_division_scan_unit ptds_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_ptds_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .value_i      (value_i),
  .last_item_i  (last_item_i),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .prime_flag_o (prime_flag_o),
  .any_prime_o  (any_prime_o),
  .last_result_o(last_result_o)
);
